FILE: design/ilt_pkg.sv
// ----------------------------------------------------------------------------
// ilt_pkg: image layout tracker shared definitions
// Command codes, dense layout codes, Vulkan barrier tables and the
// structs passed between the sequencer and the barrier unit.
// ----------------------------------------------------------------------------
`default_nettype none
package ilt_pkg;

  localparam logic [2:0] CMD_TRACKED  = 3'd0;
  localparam logic [2:0] CMD_EXPLICIT = 3'd1;
  localparam logic [2:0] CMD_SET      = 3'd2;
  localparam logic [2:0] CMD_REMOVE   = 3'd3;
  localparam logic [2:0] CMD_LOOKUP   = 3'd4;
  localparam logic [2:0] CMD_CLEAR    = 3'd5;
  // unassigned codes: no effect, zero result
  localparam logic [2:0] CMD_RSVD6    = 3'd6;
  localparam logic [2:0] CMD_RSVD7    = 3'd7;

  localparam logic [3:0] LAY_UNDEF    = 4'd0;
  localparam logic [3:0] LAY_GENERAL  = 4'd1;
  localparam logic [3:0] LAY_COLOR    = 4'd2;
  localparam logic [3:0] LAY_DEPTH    = 4'd3;
  localparam logic [3:0] LAY_SHADER   = 4'd4;
  localparam logic [3:0] LAY_XFER_SRC = 4'd5;
  localparam logic [3:0] LAY_XFER_DST = 4'd6;
  localparam logic [3:0] LAY_PRESENT  = 4'd7;
  localparam logic [3:0] LAY_OTHER    = 4'd8;

  localparam logic [31:0] ST_TOP         = 32'h0000_0001;
  localparam logic [31:0] ST_FRAG_SHADER = 32'h0000_0080;
  localparam logic [31:0] ST_EARLY_FRAG  = 32'h0000_0100;
  localparam logic [31:0] ST_LATE_FRAG   = 32'h0000_0200;
  localparam logic [31:0] ST_COLOR_OUT   = 32'h0000_0400;
  localparam logic [31:0] ST_TRANSFER    = 32'h0000_1000;
  localparam logic [31:0] ST_ALL_CMDS    = 32'h0001_0000;
  localparam logic [31:0] AC_NONE        = 32'h0000_0000;
  localparam logic [31:0] AC_INPUT_ATT_RD = 32'h0000_0010;
  localparam logic [31:0] AC_SHADER_RD   = 32'h0000_0020;
  localparam logic [31:0] AC_COLOR_WR    = 32'h0000_0100;
  localparam logic [31:0] AC_DS_WR       = 32'h0000_0400;
  localparam logic [31:0] AC_XFER_RD     = 32'h0000_0800;
  localparam logic [31:0] AC_XFER_WR     = 32'h0000_1000;
  localparam logic [31:0] AC_MEM_RW      = 32'h0001_8000;

  typedef struct packed {
    logic [3:0]  prior_layout;
    logic [3:0]  want_layout;
    logic [31:0] src_override;
    logic [31:0] dst_override;
    logic [31:0] aspect;
  } bar_req_t;

  typedef struct packed {
    logic        issued;
    logic [31:0] src_stg;
    logic [31:0] dst_stg;
    logic [31:0] src_acc;
    logic [31:0] dst_acc;
    logic [31:0] aspect;
  } bar_rsp_t;

  // layout codes above LAY_OTHER fold into LAY_OTHER
  function automatic logic [3:0] clamp_layout(input logic [3:0] v);
    return (v > LAY_OTHER) ? LAY_OTHER : v;
  endfunction

  function automatic logic [31:0] src_stage_tab(input logic [3:0] l);
    logic [31:0] r;
    case (l)
      LAY_UNDEF:    r = ST_TOP;
      LAY_GENERAL:  r = ST_ALL_CMDS;
      LAY_COLOR:    r = ST_COLOR_OUT;
      LAY_DEPTH:    r = ST_EARLY_FRAG | ST_LATE_FRAG;
      LAY_SHADER:   r = ST_FRAG_SHADER;
      LAY_XFER_SRC: r = ST_TRANSFER;
      LAY_XFER_DST: r = ST_TRANSFER;
      LAY_PRESENT:  r = ST_TRANSFER;
      default:      r = ST_ALL_CMDS;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] src_access_tab(input logic [3:0] l);
    logic [31:0] r;
    case (l)
      LAY_UNDEF:    r = AC_NONE;
      LAY_GENERAL:  r = AC_MEM_RW;
      LAY_COLOR:    r = AC_COLOR_WR;
      LAY_DEPTH:    r = AC_DS_WR;
      LAY_SHADER:   r = AC_SHADER_RD;
      LAY_XFER_SRC: r = AC_XFER_RD;
      LAY_XFER_DST: r = AC_XFER_WR;
      LAY_PRESENT:  r = AC_NONE;
      default:      r = AC_MEM_RW;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] dst_stage_tab(input logic [3:0] l);
    logic [31:0] r;
    case (l)
      LAY_UNDEF:    r = ST_ALL_CMDS;
      LAY_GENERAL:  r = ST_ALL_CMDS;
      LAY_COLOR:    r = ST_COLOR_OUT;
      LAY_DEPTH:    r = ST_EARLY_FRAG;
      LAY_SHADER:   r = ST_FRAG_SHADER;
      LAY_XFER_SRC: r = ST_TRANSFER;
      LAY_XFER_DST: r = ST_TRANSFER;
      LAY_PRESENT:  r = ST_TRANSFER;
      default:      r = ST_ALL_CMDS;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] dst_access_tab(input logic [3:0] l);
    logic [31:0] r;
    case (l)
      LAY_UNDEF:    r = AC_MEM_RW;
      LAY_GENERAL:  r = AC_MEM_RW;
      LAY_COLOR:    r = AC_COLOR_WR;
      LAY_DEPTH:    r = AC_DS_WR;
      LAY_SHADER:   r = AC_SHADER_RD | AC_INPUT_ATT_RD;
      LAY_XFER_SRC: r = AC_XFER_RD;
      LAY_XFER_DST: r = AC_XFER_WR;
      LAY_PRESENT:  r = AC_NONE;
      default:      r = AC_MEM_RW;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/ilt_if.sv
// ----------------------------------------------------------------------------
// ilt_if: request and response channels of the layout tracker
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
`default_nettype none
interface ilt_req_if #(parameter int HANDLE_BITS = 64);
  logic                   valid;
  logic                   ready;
  logic [2:0]             command;
  logic [HANDLE_BITS-1:0] image_handle;
  logic [3:0]             want_layout;
  logic [3:0]             given_old_layout;
  logic [31:0]            src_stage_ovr;
  logic [31:0]            dst_stage_ovr;
  logic [31:0]            aspect_mask;
  logic                   buffer_valid;

  modport source (output valid, command, image_handle, want_layout, given_old_layout,
                  src_stage_ovr, dst_stage_ovr, aspect_mask, buffer_valid,
                  input ready);
  modport sink (input valid, command, image_handle, want_layout, given_old_layout,
                src_stage_ovr, dst_stage_ovr, aspect_mask, buffer_valid,
                output ready);
endinterface

interface ilt_rsp_if;
  logic        valid;
  logic        ready;
  logic        barrier_issued;
  logic [3:0]  old_layout_out;
  logic [31:0] src_stage_mask;
  logic [31:0] dst_stage_mask;
  logic [31:0] src_access_mask;
  logic [31:0] dst_access_mask;
  logic [31:0] barrier_aspect;
  logic        was_tracked;
  logic        pool_full;

  modport source (output valid, barrier_issued, old_layout_out, src_stage_mask,
                  dst_stage_mask, src_access_mask, dst_access_mask, barrier_aspect,
                  was_tracked, pool_full, input ready);
  modport sink (input valid, barrier_issued, old_layout_out, src_stage_mask,
                dst_stage_mask, src_access_mask, dst_access_mask, barrier_aspect,
                was_tracked, pool_full, output ready);
endinterface
`default_nettype wire

FILE: design/ilt_ram.sv
// ----------------------------------------------------------------------------
// ilt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ilt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/ilt_barrier.sv
// ----------------------------------------------------------------------------
// ilt_barrier: barrier mask generation
// Table lookup of stage/access masks with stage overrides.
// ----------------------------------------------------------------------------
`default_nettype none
module ilt_barrier (
  input  wire ilt_pkg::bar_req_t req,
  output      ilt_pkg::bar_rsp_t rsp
);
  import ilt_pkg::*;

  always_comb begin
    rsp = '0;
    if (req.prior_layout != req.want_layout) begin
      rsp.issued  = 1'b1;
      // source override only applies when coming from undefined
      rsp.src_stg = (req.prior_layout == LAY_UNDEF && req.src_override != '0) ?
                    req.src_override : src_stage_tab(req.prior_layout);
      rsp.dst_stg = (req.dst_override != '0) ? req.dst_override :
                    dst_stage_tab(req.want_layout);
      rsp.src_acc = src_access_tab(req.prior_layout);
      rsp.dst_acc = dst_access_tab(req.want_layout);
      rsp.aspect  = req.aspect;
    end
  end
endmodule
`default_nettype wire

FILE: design/image_layout_tracker_barrier_gen.sv
// ----------------------------------------------------------------------------
// image_layout_tracker_barrier_gen: per-image layout tracker with barriers
// Chained hash table (bucket head RAM plus bump-allocated entry pool)
// walked by a small sequencer, one chain entry per cycle.
// Steps: head read (S_HEAD), chain walk (S_ENT), action (S_ACT), result
//   held (S_OUT); null/ignored commands skip to the result, clear sweeps first.
// Throughput: one transaction at a time; the next request is taken in the
//   cycle after the response transaction completes. Rate set by the entry
//   RAM read loop.
// Reset: synchronous; a sweep over all buckets zeroes the bucket heads,
//   during which no request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module image_layout_tracker_barrier_gen #(
  parameter int BUCKETS      = 1024,   // power of two
  parameter int POOL_ENTRIES = 2048,
  parameter int HANDLE_BITS  = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  ilt_req_if.sink    req,
  ilt_rsp_if.source  rsp
);
  import ilt_pkg::*;

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int PTR_W = $clog2(POOL_ENTRIES + 1);   // index + 1, 0 = end
  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);
  localparam logic [PTR_W-1:0] POOL_MAX = PTR_W'(POOL_ENTRIES);

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;  // bucket head sweep
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;  // head read returning
  localparam logic [2:0] S_ENT  = 3'd3;  // entry read returning
  localparam logic [2:0] S_ACT  = 3'd4;  // update table, build result
  localparam logic [2:0] S_OUT  = 3'd5;  // result held

  logic [2:0] state;
  logic [BKT_W-1:0] sweep;
  logic clr_rsp;

  // latched request
  logic [2:0]             cmd;
  logic [HANDLE_BITS-1:0] handle;
  logic [3:0]             nl, gl;
  logic [31:0]            so, dso, asp;
  logic [BKT_W-1:0]       bkt;

  // walk state
  logic [PTR_W-1:0] head_val, cur, prev, link, used;
  logic             found;
  logic [3:0]       old_l;

  // RAM ports
  logic             head_we;
  logic [BKT_W-1:0] head_waddr, head_raddr;
  logic [PTR_W-1:0] head_wdata, head_rdata;
  logic             hnd_we, lay_we, lnk_we;
  logic [IDX_W-1:0] hnd_waddr, lay_waddr, lnk_waddr, ent_raddr;
  logic [3:0]       lay_wdata;
  logic [PTR_W-1:0] lnk_wdata;
  logic [HANDLE_BITS-1:0] ent_handle;
  logic [3:0]       ent_layout;
  logic [PTR_W-1:0] ent_link;

  bar_req_t breq;
  bar_rsp_t brsp;

  // result register
  logic        out_valid, o_issued, o_tracked, o_full;
  logic [3:0]  o_old;
  logic [31:0] o_ss, o_ds, o_sa, o_da, o_asp;

  // bucket = low bits of h ^ (h >> 16)
  function automatic logic [BKT_W-1:0] bucket_of(input logic [HANDLE_BITS-1:0] h);
    logic [HANDLE_BITS-1:0] x;
    x = h ^ (h >> 16);
    return x[BKT_W-1:0];
  endfunction

  ilt_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_heads (
    .clk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata));
  ilt_ram #(.WIDTH(HANDLE_BITS), .DEPTH(POOL_ENTRIES)) u_handles (
    .clk, .we(hnd_we), .waddr(hnd_waddr), .wdata(handle),
    .raddr(ent_raddr), .rdata(ent_handle));
  ilt_ram #(.WIDTH(4), .DEPTH(POOL_ENTRIES)) u_layouts (
    .clk, .we(lay_we), .waddr(lay_waddr), .wdata(lay_wdata),
    .raddr(ent_raddr), .rdata(ent_layout));
  ilt_ram #(.WIDTH(PTR_W), .DEPTH(POOL_ENTRIES)) u_links (
    .clk, .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
    .raddr(ent_raddr), .rdata(ent_link));

  ilt_barrier u_barrier (.req(breq), .rsp(brsp));

  // decode of the action step
  logic is_xfer, old_eff_ne, do_write, do_insert, pool_out;
  logic [3:0] old_eff;

  always_comb begin
    old_eff    = (cmd == CMD_EXPLICIT) ? gl : (found ? old_l : LAY_UNDEF);
    is_xfer    = (cmd == CMD_TRACKED) || (cmd == CMD_EXPLICIT);
    old_eff_ne = (old_eff != nl);
    do_write   = (cmd == CMD_SET) || (is_xfer && (cmd == CMD_EXPLICIT || old_eff_ne));
    pool_out   = (used >= POOL_MAX);
    do_insert  = do_write && !found && !pool_out;

    breq.prior_layout = old_eff;
    breq.want_layout  = nl;
    breq.src_override = so;
    breq.dst_override = dso;
    breq.aspect       = asp;
  end

  // RAM addressing and writes
  always_comb begin
    head_raddr = bucket_of(req.image_handle);
    ent_raddr  = (state == S_HEAD) ? IDX_W'(head_rdata - PTR_W'(1)) :
                                     IDX_W'(ent_link - PTR_W'(1));
    head_we    = 1'b0;
    head_waddr = bkt;
    head_wdata = '0;
    hnd_we     = 1'b0;
    hnd_waddr  = used[IDX_W-1:0];
    lay_we     = 1'b0;
    lay_waddr  = used[IDX_W-1:0];
    lay_wdata  = nl;
    lnk_we     = 1'b0;
    lnk_waddr  = used[IDX_W-1:0];
    lnk_wdata  = head_val;
    if (state == S_CLR) begin
      head_we    = 1'b1;
      head_waddr = sweep;
    end else if (state == S_ACT) begin
      if (cmd == CMD_REMOVE && found) begin
        // unlink: predecessor (or head) takes the removed entry's link
        if (prev == '0) begin
          head_we    = 1'b1;
          head_wdata = link;
        end else begin
          lnk_we    = 1'b1;
          lnk_waddr = IDX_W'(prev - PTR_W'(1));
          lnk_wdata = link;
        end
      end else if (do_write && found) begin
        lay_we    = 1'b1;
        lay_waddr = IDX_W'(cur - PTR_W'(1));
      end else if (do_insert) begin
        // push new entry on front of its chain
        hnd_we     = 1'b1;
        lay_we     = 1'b1;
        lnk_we     = 1'b1;
        head_we    = 1'b1;
        head_wdata = used + PTR_W'(1);
      end
    end
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      sweep     <= '0;
      clr_rsp   <= 1'b0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          sweep <= sweep + BKT_W'(1);
          if (sweep == BKT_LAST) begin
            used    <= '0;
            clr_rsp <= 1'b0;
            if (clr_rsp) begin
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cmd      <= req.command;
            handle   <= req.image_handle;
            nl       <= clamp_layout(req.want_layout);
            gl       <= clamp_layout(req.given_old_layout);
            so       <= req.src_stage_ovr;
            dso      <= req.dst_stage_ovr;
            asp      <= req.aspect_mask;
            bkt      <= bucket_of(req.image_handle);
            o_issued <= 1'b0;
            o_tracked <= 1'b0;
            o_full   <= 1'b0;
            o_old    <= '0;
            o_ss     <= '0;
            o_ds     <= '0;
            o_sa     <= '0;
            o_da     <= '0;
            o_asp    <= '0;
            if (req.command == CMD_CLEAR) begin
              sweep   <= '0;
              clr_rsp <= 1'b1;
              state   <= S_CLR;
            end else if (req.command > CMD_CLEAR || req.image_handle == '0 ||
                         ((req.command == CMD_TRACKED || req.command == CMD_EXPLICIT)
                          && !req.buffer_valid)) begin
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          head_val <= head_rdata;
          cur      <= head_rdata;
          prev     <= '0;
          found    <= 1'b0;
          state    <= (head_rdata == '0) ? S_ACT : S_ENT;
        end
        S_ENT: begin
          if (ent_handle == handle) begin
            found <= 1'b1;
            old_l <= ent_layout;
            link  <= ent_link;
            state <= S_ACT;
          end else begin
            prev <= cur;
            cur  <= ent_link;
            if (ent_link == '0) begin
              state <= S_ACT;
            end
          end
        end
        S_ACT: begin
          o_tracked <= found;
          if (cmd == CMD_LOOKUP || cmd == CMD_REMOVE) begin
            o_old <= found ? old_l : LAY_UNDEF;
          end else begin
            o_old  <= old_eff;
            o_full <= do_write && !found && pool_out;
          end
          if (is_xfer) begin
            o_issued <= brsp.issued;
            o_ss     <= brsp.src_stg;
            o_ds     <= brsp.dst_stg;
            o_sa     <= brsp.src_acc;
            o_da     <= brsp.dst_acc;
            o_asp    <= brsp.aspect;
          end
          if (do_insert && cmd != CMD_LOOKUP && cmd != CMD_REMOVE) begin
            used <= used + PTR_W'(1);
          end
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.barrier_issued  = o_issued;
  assign rsp.old_layout_out  = o_old;
  assign rsp.src_stage_mask  = o_ss;
  assign rsp.dst_stage_mask  = o_ds;
  assign rsp.src_access_mask = o_sa;
  assign rsp.dst_access_mask = o_da;
  assign rsp.barrier_aspect  = o_asp;
  assign rsp.was_tracked     = o_tracked;
  assign rsp.pool_full       = o_full;
endmodule
`default_nettype wire

FILE: design/ilt_checker.sv
// ----------------------------------------------------------------------------
// ilt_checker: port-level checks of the layout tracker
// Observes request/response ports only; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ilt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        issued,
  input wire logic        tracked,
  input wire logic        full,
  input wire logic [31:0] src_mask,
  input wire logic [31:0] aspect
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("response dropped");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken with response pending");

  a_nobar: assert property (@(posedge clk) disable iff (rst)
    out_valid && !issued |-> (src_mask == '0 && aspect == '0))
    else $error("masks set without barrier");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && full |-> !tracked) else $error("pool full on tracked handle");

  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready) else $error("active after reset");
endmodule

bind image_layout_tracker_barrier_gen ilt_checker u_ilt_checker (
  .clk(clk), .rst(rst), .in_ready(req.ready), .out_valid(rsp.valid),
  .out_ready(rsp.ready), .issued(rsp.barrier_issued), .tracked(rsp.was_tracked),
  .full(rsp.pool_full), .src_mask(rsp.src_stage_mask), .aspect(rsp.barrier_aspect));
`default_nettype wire
